@@ sv/cas_pkg.sv @@
// Shared types, constants and helper functions of the cave automaton row step.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    // Row geometry
    localparam int MAX_WIDTH   = 64;
    localparam int ROW_W       = 64;
    localparam int GW_W        = 7;
    localparam int QUEUE_DEPTH = 3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_WEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_CUTOFF = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_CUTOFF  = 4'd3;

    // Rule settings seen by the row evaluators
    typedef struct packed {
        logic [GW_W-1:0]   width;
        logic [7:0]        near_weight;
        logic [11:0]       near_cutoff;
        logic signed [5:0] far_cutoff;
    } cas_rule_t;

    // One result row waiting for transfer
    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic             last;
    } cas_entry_t;

    // Up to three result rows offered to the output queue in one cycle
    typedef struct packed {
        logic                         valid;
        logic [1:0]                   count;
        cas_entry_t [QUEUE_DEPTH-1:0] rows;
    } cas_push_t;

    // Clamp the programmed width to the widest supported row
    function automatic logic [GW_W-1:0] cas_width_in_use(input logic [GW_W-1:0] gw);
        logic [GW_W-1:0] w;
        w = gw;
        if (gw > GW_W'(MAX_WIDTH))
        begin
            w = GW_W'(MAX_WIDTH);
        end
        return w;
    endfunction

    // Mask of the cells in use: bit i set where i lies below the width
    function automatic logic [ROW_W-1:0] cas_width_mask(input logic [GW_W-1:0] w);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++)
        begin
            m[i] = (GW_W'(i) < w);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ sv/cas_ifs.sv @@
// Handshake channel interfaces: input rows, result rows and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface cas_row_if import cas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_cells;
    logic             final_row;

    modport source (output valid, output row_cells, output final_row, input ready);
    modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface cas_result_if import cas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] next_cells;
    logic             last_out;

    modport source (output valid, output next_cells, output last_out, input ready);
    modport sink   (input valid, input next_cells, input last_out, output ready);
endinterface

interface cas_cfg_if import cas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/cas_row_eval.sv @@
// Next-generation evaluation of one grid row from its two neighbours above and below.
`timescale 1ns / 1ps
`default_nettype none

module cas_row_eval import cas_pkg::*;
(
    input  wire logic [ROW_W-1:0] above2,
    input  wire logic [ROW_W-1:0] above1,
    input  wire logic [ROW_W-1:0] middle,
    input  wire logic [ROW_W-1:0] below1,
    input  wire logic [ROW_W-1:0] below2,
    input  wire logic             border,
    input  wire cas_rule_t        rule,
    output logic [ROW_W-1:0]      next_row
);

    // Column sums, padded by two dead columns on each side
    logic [1:0]  col3 [ROW_W+4];
    logic [2:0]  col5 [ROW_W+4];
    logic [3:0]  near_cnt [ROW_W];
    logic [4:0]  far_cnt [ROW_W];
    logic [11:0] near_score [ROW_W];
    logic [ROW_W-1:0] live;

    // Form vertical sums of three and five rows per column
    always_comb
    begin
        for (int i = 0; i < ROW_W + 4; i++)
        begin
            col3[i] = 2'd0;
            col5[i] = 3'd0;
        end
        for (int i = 0; i < ROW_W; i++)
        begin
            col3[i+2] = 2'(above1[i]) + 2'(middle[i]) + 2'(below1[i]);
            col5[i+2] = 3'(col3[i+2]) + 3'(above2[i]) + 3'(below2[i]);
        end
    end

    // Count the neighbourhoods and apply both rules per cell
    always_comb
    begin
        for (int x = 0; x < ROW_W; x++)
        begin
            near_cnt[x]   = 4'(col3[x+1]) + 4'(col3[x+2]) + 4'(col3[x+3]);
            far_cnt[x]    = 5'(col5[x+1]) + 5'(col5[x+2]) + 5'(col5[x+3])
                          + 5'(col3[x]) + 5'(col3[x+4]);
            near_score[x] = 12'(near_cnt[x]) * 12'(rule.near_weight);
            live[x]       = (near_score[x] >= rule.near_cutoff)
                         || ($signed({2'b00, far_cnt[x]})
                             <= $signed({rule.far_cutoff[5], rule.far_cutoff}));
        end
    end

    // Keep a border row whole; otherwise keep the border columns and replace interior columns by the rule outcome
    always_comb
    begin
        next_row = middle;
        if (!border)
        begin
            for (int x = 1; x < ROW_W; x++)
            begin
                if (GW_W'(x + 1) < rule.width)
                begin
                    next_row[x] = live[x];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/cas_out_queue.sv @@
// Three-entry result queue that takes up to three rows at once and hands out one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module cas_out_queue import cas_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cas_push_t push,
    output logic           push_ready,
    cas_result_if.source   results
);

    cas_entry_t q_reg [QUEUE_DEPTH];
    cas_entry_t q_next [QUEUE_DEPTH];
    cas_entry_t q_base [QUEUE_DEPTH];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] cnt_after_pop;
    logic [2:0] cnt_sum;
    logic       pop;
    logic       push_fire;

    // Present the head entry
    assign results.valid      = (cnt_reg != 2'd0);
    assign results.next_cells = q_reg[0].cells;
    assign results.last_out   = q_reg[0].last;

    // Work out room after this cycle's transfer
    assign pop           = results.valid && results.ready;
    assign cnt_after_pop = cnt_reg - 2'(pop);
    assign cnt_sum       = {1'b0, cnt_after_pop} + {1'b0, push.count};
    assign push_ready    = (cnt_sum <= 3'(QUEUE_DEPTH));
    assign push_fire     = push.valid && push_ready;

    // Advance the queue on a transfer, then append the new rows behind the survivors
    always_comb
    begin
        q_base[0] = pop ? q_reg[1] : q_reg[0];
        q_base[1] = pop ? q_reg[2] : q_reg[1];
        q_base[2] = q_reg[2];
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            q_next[k] = q_base[k];
            if (push_fire && (2'(k) >= cnt_after_pop) && (3'(k) < cnt_sum))
            begin
                q_next[k] = push.rows[2'(k) - cnt_after_pop];
            end
        end
        cnt_next = push_fire ? cnt_sum[1:0] : cnt_after_pop;
    end

    // Hold the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            q_reg[k] <= q_next[k];
        end
    end

endmodule

`default_nettype wire

@@ sv/cave_automaton_row_step.sv @@
// Top level of the streaming cave automaton: one generation, one grid row per transfer.
`timescale 1ns / 1ps
`default_nettype none

// Rows enter from the top of the grid, one per transfer, with final_row on the bottom
// row. An accepted row is registered in the input stage together with a copy of the
// four rows before it; from there two row evaluators work out the new rows side by
// side and place them, once there is room, in a three-entry result queue whose head
// drives the result channel. While the result channel stays ready a row can be
// accepted in every cycle, so ordinary rows stream at one per cycle through the input
// stage and the queue; output row y waits for the arrival of input row y+2. The final
// row yields up to three results at once (the two rows still open and itself); while
// the channel stays ready the queue drains them at one per cycle and the input never
// stalls, because the rows that follow release no more results than have left by then.
// A stalled result channel fills the queue and then holds the input. After the final
// row the history is cleared and the next row starts a new grid. Configuration writes
// are accepted in every cycle and must only be made while no row is under way.
module cave_automaton_row_step import cas_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    cas_cfg_if.sink      cfg,
    cas_row_if.sink      rows,
    cas_result_if.source results
);

    // Configuration registers
    logic [GW_W-1:0]   grid_width_reg;
    logic [7:0]        near_weight_reg;
    logic [11:0]       near_cutoff_reg;
    logic signed [5:0] far_cutoff_reg;

    // Row history, newest first, and rows taken in this grid, saturating at four
    logic [ROW_W-1:0] hist_reg [4];
    logic [2:0]       rows_seen_reg;

    // Input stage
    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_cur_reg;
    logic             s1_fin_reg;
    logic [ROW_W-1:0] s1_hist_reg [4];
    logic [2:0]       s1_seen_reg;

    logic [GW_W-1:0]  width_now;
    logic [ROW_W-1:0] mask_now;
    logic [ROW_W-1:0] cur_masked;
    logic             row_fire;
    logic             push_ready;
    cas_rule_t        rule;
    cas_push_t        push;
    logic [ROW_W-1:0] eval_full;
    logic [ROW_W-1:0] eval_tail;
    logic             seen_ge1;
    logic             seen_ge2;

    assign width_now  = cas_width_in_use(grid_width_reg);
    assign mask_now   = cas_width_mask(width_now);
    assign cur_masked = rows.row_cells & mask_now;

    // Take writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW_W'(16);
            near_weight_reg <= 8'd1;
            near_cutoff_reg <= 12'd5;
            far_cutoff_reg  <= 6'sd2;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg.data[GW_W-1:0];
                REG_NEAR_WEIGHT: near_weight_reg <= cfg.data[7:0];
                REG_NEAR_CUTOFF: near_cutoff_reg <= cfg.data[11:0];
                REG_FAR_CUTOFF:  far_cutoff_reg  <= $signed(cfg.data[5:0]);
                default:         ;
            endcase
        end
    end

    // Accept a row whenever the input stage is empty or moves on this cycle
    assign rows.ready = !s1_valid_reg || push_ready;
    assign row_fire   = rows.valid && rows.ready;

    // Shift the history on an ordinary row, clear it after the bottom row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
            rows_seen_reg <= 3'd0;
        end
        else if (row_fire)
        begin
            if (rows.final_row)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    hist_reg[i] <= '0;
                end
                rows_seen_reg <= 3'd0;
            end
            else
            begin
                hist_reg[3] <= hist_reg[2];
                hist_reg[2] <= hist_reg[1];
                hist_reg[1] <= hist_reg[0];
                hist_reg[0] <= cur_masked;
                if (rows_seen_reg < 3'd4)
                begin
                    rows_seen_reg <= rows_seen_reg + 3'd1;
                end
            end
        end
    end

    // Input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rows.ready)
        begin
            s1_valid_reg <= rows.valid;
        end
    end

    // Capture the row and the history it sees
    always_ff @(posedge clk)
    begin
        if (row_fire)
        begin
            s1_cur_reg  <= cur_masked;
            s1_fin_reg  <= rows.final_row;
            s1_seen_reg <= rows_seen_reg;
            for (int i = 0; i < 4; i++)
            begin
                s1_hist_reg[i] <= hist_reg[i];
            end
        end
    end

    assign rule.width       = width_now;
    assign rule.near_weight = near_weight_reg;
    assign rule.near_cutoff = near_cutoff_reg;
    assign rule.far_cutoff  = far_cutoff_reg;

    // Row two above the newest, with two rows of context on each side
    cas_row_eval u_eval_full
    (
        .above2   (s1_hist_reg[3]),
        .above1   (s1_hist_reg[2]),
        .middle   (s1_hist_reg[1]),
        .below1   (s1_hist_reg[0]),
        .below2   (s1_cur_reg),
        .border   (s1_seen_reg == 3'd2),
        .rule     (rule),
        .next_row (eval_full)
    );

    // Row just above the bottom row, with dead cells below the grid
    cas_row_eval u_eval_tail
    (
        .above2   (s1_hist_reg[2]),
        .above1   (s1_hist_reg[1]),
        .middle   (s1_hist_reg[0]),
        .below1   (s1_cur_reg),
        .below2   ('0),
        .border   (s1_seen_reg == 3'd1),
        .rule     (rule),
        .next_row (eval_tail)
    );

    assign seen_ge2 = (s1_seen_reg >= 3'd2);
    assign seen_ge1 = (s1_seen_reg >= 3'd1);

    // Gather the result rows of the staged item in output order
    always_comb
    begin
        push.valid = s1_valid_reg;
        push.count = 2'd0;
        push.rows[0] = '{cells: eval_full & mask_now, last: 1'b0};
        push.rows[1] = '{cells: eval_tail & mask_now, last: 1'b0};
        push.rows[2] = '{cells: s1_cur_reg, last: 1'b1};
        if (!s1_fin_reg)
        begin
            push.count = seen_ge2 ? 2'd1 : 2'd0;
        end
        else if (seen_ge2)
        begin
            push.count = 2'd3;
        end
        else if (seen_ge1)
        begin
            push.count   = 2'd2;
            push.rows[0] = '{cells: eval_tail & mask_now, last: 1'b0};
            push.rows[1] = '{cells: s1_cur_reg, last: 1'b1};
        end
        else
        begin
            push.count   = 2'd1;
            push.rows[0] = '{cells: s1_cur_reg, last: 1'b1};
        end
    end

    cas_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .results    (results)
    );

endmodule

`default_nettype wire
